// ===== src/teletype_text_display_grid_macros.svh =====
// Assertion helpers for the display grid checker.
// Both expect clk in the scope where they are used; TTDG_ASSERT also expects rst_n.
`ifndef TELETYPE_TEXT_DISPLAY_GRID_MACROS_SVH
`define TELETYPE_TEXT_DISPLAY_GRID_MACROS_SVH

// Checked only while out of reset.
`define TTDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define TTDG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ttdg_pkg.sv =====
`default_nettype none

package ttdg_pkg;

  localparam int DEF_ROWS = 24;
  localparam int DEF_COLS = 40;

  localparam int OP_W      = 3;
  localparam int CHAR_W    = 8;
  localparam int ROW_SEL_W = 5;
  localparam int COL_SEL_W = 6;

  // Operation codes on in_op
  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
  localparam logic [OP_W-1:0] OP_POKE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_FILL  = 3'd4;

  // Character codes (7-bit after masking)
  localparam logic [6:0] CH_CR        = 7'h0D;
  localparam logic [6:0] CH_BS        = 7'h08;
  localparam logic [6:0] CH_ULINE     = 7'h5F;
  localparam logic [6:0] CH_PRINT_LO  = 7'h20;
  localparam logic [6:0] CH_LOWER     = 7'h60;
  localparam logic [6:0] CH_FOLD_MASK = 7'h5F;

  localparam logic [CHAR_W-1:0] CELL_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] STRIPE_EVEN  = 8'h5F;
  localparam logic [CHAR_W-1:0] STRIPE_ODD   = 8'h40;

  typedef enum logic [2:0] {
    OPK_PUT,
    OPK_CLEAR,
    OPK_POKE,
    OPK_READ,
    OPK_FILL,
    OPK_NOP
  } opk_t;

  typedef struct packed {
    opk_t                 opk;
    logic [CHAR_W-1:0]    code;
    logic [ROW_SEL_W-1:0] row_sel;
    logic [COL_SEL_W-1:0] col_sel;
    logic                 in_range;
  } item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_READ,
    ST_DONE
  } bst_t;

  typedef enum logic [1:0] {
    SW_CLEAR,
    SW_FILL,
    SW_SCROLL
  } swk_t;

endpackage

`default_nettype wire

// ===== src/ttdg_ram.sv =====
`default_nettype none

module ttdg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

`default_nettype wire

// ===== src/ttdg_front.sv =====
`default_nettype none

module ttdg_front #(
  parameter int ROWS = ttdg_pkg::DEF_ROWS,
  parameter int COLS = ttdg_pkg::DEF_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ttdg_pkg::OP_W-1:0]      in_op,
  input  wire logic [ttdg_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [ttdg_pkg::ROW_SEL_W-1:0] in_row_sel,
  input  wire logic [ttdg_pkg::COL_SEL_W-1:0] in_col_sel,
  output ttdg_pkg::item_t                     q_item,
  output logic                                q_valid,
  input  wire logic                           q_pop
);

  import ttdg_pkg::*;

  item_t       q_mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  item_t       cls_item;
  logic        push;
  logic        pop;

  // Classify the incoming word
  always_comb begin
    cls_item          = '0;
    cls_item.code     = in_char_code;
    cls_item.row_sel  = in_row_sel;
    cls_item.col_sel  = in_col_sel;
    cls_item.in_range = ({1'b0, in_row_sel} < (ROW_SEL_W+1)'(ROWS)) &&
                        ({1'b0, in_col_sel} < (COL_SEL_W+1)'(COLS));
    case (in_op)
      OP_PUT:   cls_item.opk = OPK_PUT;
      OP_CLEAR: cls_item.opk = OPK_CLEAR;
      OP_POKE:  cls_item.opk = OPK_POKE;
      OP_READ:  cls_item.opk = OPK_READ;
      OP_FILL:  cls_item.opk = OPK_FILL;
      default:  cls_item.opk = OPK_NOP;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/ttdg_back.sv =====
`default_nettype none

module ttdg_back #(
  parameter int ROWS = ttdg_pkg::DEF_ROWS,
  parameter int COLS = ttdg_pkg::DEF_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ttdg_pkg::item_t                q_item,
  input  wire logic                           q_valid,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ttdg_pkg::CHAR_W-1:0]         out_cell_value,
  output logic [ttdg_pkg::ROW_SEL_W-1:0]      out_cur_row,
  output logic [ttdg_pkg::COL_SEL_W-1:0]      out_cur_col,
  output logic                                out_line_wrapped,
  output logic                                out_consumed
);

  import ttdg_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int CCW   = $clog2(COLS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;

  localparam logic [RW:0]    ROWS_V   = (RW+1)'(ROWS);
  localparam logic [RW-1:0]  LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0]  LAST_COL = CW'(COLS - 1);
  localparam logic [CCW-1:0] COLS_C   = CCW'(COLS);

  bst_t              state_r, state_nxt;
  item_t             item_r, item_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [CCW-1:0]    cur_col_r, cur_col_nxt;
  logic [RW-1:0]     top_r, top_nxt;
  swk_t              sw_kind_r, sw_kind_nxt;
  logic [RW-1:0]     sw_row_r, sw_row_nxt;
  logic [CW-1:0]     sw_col_r, sw_col_nxt;
  logic              sw_pend_r, sw_pend_nxt;
  logic [CHAR_W-1:0] sw_char_r, sw_char_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic              consumed_r, consumed_nxt;
  logic [CHAR_W-1:0] value_r, value_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_value_r, out_value_nxt;
  logic [ROW_SEL_W-1:0] out_row_r, out_row_nxt;
  logic [COL_SEL_W-1:0] out_col_r, out_col_nxt;
  logic                 out_wrap_r, out_wrap_nxt;
  logic                 out_cons_r, out_cons_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic [6:0]  ch7;
  logic [6:0]  ch_fold;
  logic        is_cr, is_bs, is_prn;
  logic        parked, at_bottom;
  logic        need_scroll, exec_sweep, exec_read;
  logic        sw_last_col, sweep_end;
  logic        out_free;
  logic [RW-1:0] sel_prow;

  // Logical screen row to physical store row
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] r);
    logic [RW:0] s;
    s = {1'b0, top} + {1'b0, r};
    if (s >= ROWS_V) begin
      s = s - ROWS_V;
    end
    return s[RW-1:0];
  endfunction

  assign ch7       = item_r.code[6:0];
  assign ch_fold   = (ch7 >= CH_LOWER) ? (ch7 & CH_FOLD_MASK) : ch7;
  assign is_cr     = (ch7 == CH_CR);
  assign is_bs     = (ch7 == CH_BS) || (ch7 == CH_ULINE);
  assign is_prn    = (ch7 >= CH_PRINT_LO);
  assign parked    = (cur_col_r == COLS_C);
  assign at_bottom = (cur_row_r == LAST_ROW);

  assign need_scroll = (item_r.opk == OPK_PUT) && at_bottom &&
                       (is_cr || (!is_bs && is_prn && parked));
  assign exec_sweep  = (item_r.opk == OPK_CLEAR) || (item_r.opk == OPK_FILL) ||
                       need_scroll;
  assign exec_read   = (item_r.opk == OPK_READ) && item_r.in_range;

  assign sw_last_col = (sw_col_r == LAST_COL);
  assign sweep_end   = sw_last_col && ((sw_kind_r == SW_SCROLL) || (sw_row_r == LAST_ROW));
  assign out_free    = !out_valid_r || out_ready;
  assign sel_prow    = phys_row(top_r, item_r.row_sel[RW-1:0]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sw_last_col && (sw_row_r == LAST_ROW)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_sweep) begin
          state_nxt = ST_SWEEP;
        end else if (exec_read) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SWEEP: begin
        if (sweep_end) state_nxt = ST_DONE;
      end
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    item_nxt      = item_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    sw_kind_nxt   = sw_kind_r;
    sw_row_nxt    = sw_row_r;
    sw_col_nxt    = sw_col_r;
    sw_pend_nxt   = sw_pend_r;
    sw_char_nxt   = sw_char_r;
    wrapped_nxt   = wrapped_r;
    consumed_nxt  = consumed_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_wrap_nxt  = out_wrap_r;
    out_cons_nxt  = out_cons_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {sel_prow, item_r.col_sel[CW-1:0]};
    ram_wdata     = item_r.code;
    ram_re        = 1'b0;
    ram_raddr     = {sel_prow, item_r.col_sel[CW-1:0]};

    case (state_r)
      ST_INIT, ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = {sw_row_r, sw_col_r};
        case (sw_kind_r)
          SW_FILL:   ram_wdata = sw_col_r[0] ? STRIPE_ODD : STRIPE_EVEN;
          SW_SCROLL: ram_wdata = (sw_pend_r && (sw_col_r == '0)) ? sw_char_r : CELL_SPACE;
          default:   ram_wdata = CELL_SPACE;
        endcase
        sw_col_nxt = sw_last_col ? '0 : sw_col_r + CW'(1);
        if (sw_last_col && (sw_kind_r != SW_SCROLL)) begin
          sw_row_nxt = (sw_row_r == LAST_ROW) ? '0 : sw_row_r + RW'(1);
        end
        // Blanked row becomes the new bottom line
        if (sweep_end && (sw_kind_r == SW_SCROLL)) begin
          top_nxt = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
        end
      end

      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
        end
      end

      ST_EXEC: begin
        wrapped_nxt  = 1'b0;
        consumed_nxt = 1'b0;
        value_nxt    = '0;
        sw_col_nxt   = '0;
        sw_pend_nxt  = 1'b0;
        case (item_r.opk)
          OPK_PUT: begin
            if (is_cr) begin
              wrapped_nxt  = 1'b1;
              consumed_nxt = 1'b1;
              cur_col_nxt  = '0;
              if (at_bottom) begin
                sw_kind_nxt = SW_SCROLL;
                sw_row_nxt  = top_r;
              end else begin
                cur_row_nxt = cur_row_r + RW'(1);
              end
            end else if (is_bs) begin
              consumed_nxt = 1'b1;
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - CCW'(1);
                ram_we      = 1'b1;
                ram_waddr   = {phys_row(top_r, cur_row_r), CW'(cur_col_r - CCW'(1))};
                ram_wdata   = CELL_SPACE;
              end
            end else if (is_prn) begin
              consumed_nxt = 1'b1;
              if (parked) begin
                wrapped_nxt = 1'b1;
                cur_col_nxt = CCW'(1);
                if (at_bottom) begin
                  // Character lands at column zero during the scroll sweep
                  sw_kind_nxt = SW_SCROLL;
                  sw_row_nxt  = top_r;
                  sw_pend_nxt = 1'b1;
                  sw_char_nxt = {1'b0, ch_fold};
                end else begin
                  cur_row_nxt = cur_row_r + RW'(1);
                  ram_we      = 1'b1;
                  ram_waddr   = {phys_row(top_r, cur_row_r + RW'(1)), CW'(0)};
                  ram_wdata   = {1'b0, ch_fold};
                end
              end else begin
                cur_col_nxt = cur_col_r + CCW'(1);
                ram_we      = 1'b1;
                ram_waddr   = {phys_row(top_r, cur_row_r), cur_col_r[CW-1:0]};
                ram_wdata   = {1'b0, ch_fold};
              end
            end
          end
          OPK_CLEAR: begin
            consumed_nxt = 1'b1;
            cur_row_nxt  = '0;
            cur_col_nxt  = '0;
            top_nxt      = '0;
            sw_kind_nxt  = SW_CLEAR;
            sw_row_nxt   = '0;
          end
          OPK_FILL: begin
            consumed_nxt = 1'b1;
            sw_kind_nxt  = SW_FILL;
            sw_row_nxt   = '0;
          end
          OPK_POKE: begin
            if (item_r.in_range) begin
              consumed_nxt = 1'b1;
              ram_we       = 1'b1;
            end
          end
          OPK_READ: begin
            ram_re = item_r.in_range;
          end
          default: begin
          end
        endcase
      end

      ST_READ: begin
        value_nxt = ram_rdata;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = value_r;
          out_row_nxt   = ROW_SEL_W'(cur_row_r);
          out_col_nxt   = COL_SEL_W'(cur_col_r);
          out_wrap_nxt  = wrapped_r;
          out_cons_nxt  = consumed_r;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      sw_kind_r   <= SW_CLEAR;
      sw_row_r    <= '0;
      sw_col_r    <= '0;
      sw_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      sw_kind_r   <= sw_kind_nxt;
      sw_row_r    <= sw_row_nxt;
      sw_col_r    <= sw_col_nxt;
      sw_pend_r   <= sw_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    sw_char_r   <= sw_char_nxt;
    wrapped_r   <= wrapped_nxt;
    consumed_r  <= consumed_nxt;
    value_r     <= value_nxt;
    out_value_r <= out_value_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_wrap_r  <= out_wrap_nxt;
    out_cons_r  <= out_cons_nxt;
  end

  ttdg_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_cell_value   = out_value_r;
  assign out_cur_row      = out_row_r;
  assign out_cur_col      = out_col_r;
  assign out_line_wrapped = out_wrap_r;
  assign out_consumed     = out_cons_r;

endmodule

`default_nettype wire

// ===== src/teletype_text_display_grid.sv =====
// Text terminal character grid with a cursor, ROWS x COLS byte cells.
// Input channel (in_valid/in_ready): one operation word per handshake:
//   put char, clear screen, poke cell, read cell, fill stripe pattern.
// Result channel (out_valid/out_ready): exactly one result word per input
//   word, in order: read data, cursor position, wrap and consumed flags.
// A two-entry queue decodes and holds incoming words, so the input side
//   keeps taking words while the cell engine is busy or a result waits.
// Engine work per word (cell RAM with one write and one registered read port,
//   one write a cycle): put char, poke and ignored codes pass through the
//   execute and done states; read cell adds a state for the registered RAM read;
//   a newline at the bottom row adds a sweep that blanks one row a cell a cycle;
//   clear screen and fill stripes sweep every cell.
// Reset: cursor and scroll origin go to zero, then the engine writes spaces
//   to every cell, one a cycle, before the first word is executed; words are
//   still queued during that pass.
// A stalled result holds in the output register; the engine finishes the
//   next word only once that register frees, and the queue then fills up.
`default_nettype none

module teletype_text_display_grid #(
  parameter int ROWS = ttdg_pkg::DEF_ROWS,
  parameter int COLS = ttdg_pkg::DEF_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ttdg_pkg::OP_W-1:0]      in_op,
  input  wire logic [ttdg_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [ttdg_pkg::ROW_SEL_W-1:0] in_row_sel,
  input  wire logic [ttdg_pkg::COL_SEL_W-1:0] in_col_sel,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ttdg_pkg::CHAR_W-1:0]         out_cell_value,
  output logic [ttdg_pkg::ROW_SEL_W-1:0]      out_cur_row,
  output logic [ttdg_pkg::COL_SEL_W-1:0]      out_cur_col,
  output logic                                out_line_wrapped,
  output logic                                out_consumed
);

  import ttdg_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  ttdg_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_char_code (in_char_code),
    .in_row_sel   (in_row_sel),
    .in_col_sel   (in_col_sel),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop)
  );

  ttdg_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_item           (q_item),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_value   (out_cell_value),
    .out_cur_row      (out_cur_row),
    .out_cur_col      (out_cur_col),
    .out_line_wrapped (out_line_wrapped),
    .out_consumed     (out_consumed)
  );

endmodule

`default_nettype wire

// ===== src/ttdg_checker.sv =====
`default_nettype none
`include "teletype_text_display_grid_macros.svh"

module ttdg_checker #(
  parameter int ROWS = ttdg_pkg::DEF_ROWS,
  parameter int COLS = ttdg_pkg::DEF_COLS
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ttdg_pkg::CHAR_W-1:0]    out_cell_value,
  input wire logic [ttdg_pkg::ROW_SEL_W-1:0] out_cur_row,
  input wire logic [ttdg_pkg::COL_SEL_W-1:0] out_cur_col,
  input wire logic                           out_line_wrapped,
  input wire logic                           out_consumed
);

  import ttdg_pkg::*;

  `TTDG_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  `TTDG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_cell_value) && $stable(out_cur_row) && $stable(out_cur_col) && $stable(out_consumed), "stalled result changed")

  `TTDG_ASSERT(a_wrap_col, out_valid && out_line_wrapped |-> out_consumed && (out_cur_col == 6'd0 || out_cur_col == 6'd1), "wrap left cursor off line start")

  `TTDG_ASSERT(a_read_only, out_valid && out_cell_value != 8'd0 |-> !out_consumed && !out_line_wrapped, "cell data on a non-read result")

  `TTDG_ASSERT(a_row_range, out_valid |-> {1'b0, out_cur_row} < (ROW_SEL_W+1)'(ROWS), "cursor row out of range")

endmodule

bind teletype_text_display_grid ttdg_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_ttdg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_cell_value   (out_cell_value),
  .out_cur_row      (out_cur_row),
  .out_cur_col      (out_cur_col),
  .out_line_wrapped (out_line_wrapped),
  .out_consumed     (out_consumed)
);

`default_nettype wire

// ===== sim/tb_teletype_text_display_grid.sv =====
`default_nettype none

module tb_teletype_text_display_grid;
  timeunit 1ns;
  timeprecision 1ps;

  import ttdg_pkg::*;

  localparam int ROWS = DEF_ROWS;
  localparam int COLS = DEF_COLS;
  localparam int RAND_WORDS = 375;
  localparam int DRAIN_CYCLES = 50;

  // op codes the block does not decode
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam bit FIX = 1'b1;
  localparam bit CALC = 1'b0;

  typedef struct packed {
    logic [CHAR_W-1:0]    value;
    logic [ROW_SEL_W-1:0] row;
    logic [COL_SEL_W-1:0] col;
    logic                 wrapped;
    logic                 consumed;
  } cursor_status_t;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [CHAR_W-1:0]    code;
    logic [ROW_SEL_W-1:0] rs;
    logic [COL_SEL_W-1:0] cs;
    bit                   fixed;
    cursor_status_t       want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_op = '0;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic [ROW_SEL_W-1:0] in_row_sel = '0;
  logic [COL_SEL_W-1:0] in_col_sel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAR_W-1:0]    out_cell_value;
  logic [ROW_SEL_W-1:0] out_cur_row;
  logic [COL_SEL_W-1:0] out_cur_col;
  logic                 out_line_wrapped;
  logic                 out_consumed;

  logic [CHAR_W-1:0] shadow_cells [ROWS*COLS];
  int                shadow_row;
  int                shadow_col;
  int                shadow_top;

  cursor_status_t status_due_q [$];
  script_row_t    script_q [$];
  int             mismatch_count = 0;
  int             status_count = 0;
  int             sent_count = 0;
  int             stall_left = 0;
  int             line_left = 0;

  always #5 clk = ~clk;

  teletype_text_display_grid #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_char_code    (in_char_code),
    .in_row_sel      (in_row_sel),
    .in_col_sel      (in_col_sel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_value  (out_cell_value),
    .out_cur_row     (out_cur_row),
    .out_cur_col     (out_cur_col),
    .out_line_wrapped(out_line_wrapped),
    .out_consumed    (out_consumed)
  );

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int phys_cell(int r, int c);
    return ((shadow_top + r) % ROWS) * COLS + c;
  endfunction

  task automatic clear_shadow();
    foreach (shadow_cells[i]) shadow_cells[i] = CELL_SPACE;
    shadow_row = 0;
    shadow_col = 0;
    shadow_top = 0;
  endtask

  task automatic advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      // blank the row leaving the top; it comes back as the bottom row
      for (int c = 0; c < COLS; c++) shadow_cells[shadow_top * COLS + c] = CELL_SPACE;
      shadow_top = (shadow_top + 1) % ROWS;
      shadow_row = ROWS - 1;
    end
  endtask

  task automatic display_step(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] code,
                              input logic [ROW_SEL_W-1:0] rs,
                              input logic [COL_SEL_W-1:0] cs,
                              output cursor_status_t st);
    logic [6:0] ch;
    bit         on_screen;
    st = '0;
    ch = code[6:0];
    on_screen = (int'(rs) < ROWS) && (int'(cs) < COLS);
    case (op)
      OP_PUT: begin
        if (ch == CH_CR) begin
          advance_line();
          st.wrapped = 1'b1;
          st.consumed = 1'b1;
        end else if (ch == CH_BS || ch == CH_ULINE) begin
          if (shadow_col > 0) begin
            shadow_col--;
            shadow_cells[phys_cell(shadow_row, shadow_col)] = CELL_SPACE;
          end
          st.consumed = 1'b1;
        end else if (ch >= CH_PRINT_LO) begin
          if (ch >= CH_LOWER) ch = ch & CH_FOLD_MASK;
          // a parked cursor takes its newline only now
          if (shadow_col >= COLS) begin
            advance_line();
            st.wrapped = 1'b1;
          end
          shadow_cells[phys_cell(shadow_row, shadow_col)] = {1'b0, ch};
          shadow_col++;
          st.consumed = 1'b1;
        end
      end
      OP_CLEAR: begin
        clear_shadow();
        st.consumed = 1'b1;
      end
      OP_POKE: begin
        if (on_screen) begin
          shadow_cells[phys_cell(rs, cs)] = code;
          st.consumed = 1'b1;
        end
      end
      OP_READ: begin
        if (on_screen) st.value = shadow_cells[phys_cell(rs, cs)];
      end
      OP_FILL: begin
        // physical rows, so the scroll origin does not matter
        for (int r = 0; r < ROWS; r++)
          for (int c = 0; c < COLS; c++)
            shadow_cells[r * COLS + c] = (c % 2 != 0) ? STRIPE_ODD : STRIPE_EVEN;
        st.consumed = 1'b1;
      end
      default: ;
    endcase
    st.row = ROW_SEL_W'(shadow_row);
    st.col = COL_SEL_W'(shadow_col);
  endtask

  task automatic script_add(input logic [OP_W-1:0] op, input int code, input int rs,
                            input int cs, input bit fixed, input int value, input int row,
                            input int col, input int wrapped, input int consumed);
    script_row_t w;
    w.op = op;
    w.code = CHAR_W'(code);
    w.rs = ROW_SEL_W'(rs);
    w.cs = COL_SEL_W'(cs);
    w.fixed = fixed;
    w.want.value = CHAR_W'(value);
    w.want.row = ROW_SEL_W'(row);
    w.want.col = COL_SEL_W'(col);
    w.want.wrapped = wrapped[0];
    w.want.consumed = consumed[0];
    script_q.push_back(w);
  endtask

  task automatic next_random_word(output script_row_t w);
    int pick;
    int sub;
    pick = $urandom_range(0, 99);
    w.fixed = CALC;
    w.want = '0;
    w.op = OP_PUT;
    w.code = CHAR_W'($urandom_range(0, 255));
    w.rs = ROW_SEL_W'($urandom_range(0, 31));
    w.cs = COL_SEL_W'($urandom_range(0, 63));
    if (pick < 10) begin
      w.op = (pick < 5) ? OP_POKE : OP_READ;
      // keep most addresses on screen
      if ($urandom_range(0, 9) != 0) begin
        w.rs = ROW_SEL_W'($urandom_range(0, ROWS - 1));
        w.cs = COL_SEL_W'($urandom_range(0, COLS - 1));
      end
    end else if (pick < 12) begin
      w.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else if (pick == 12) begin
      w.op = ($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_FILL;
    end else if (line_left == 0) begin
      w.code[6:0] = CH_CR;
      // many empty lines so the screen fills and scrolls
      sub = $urandom_range(0, 99);
      if (sub < 50) line_left = 0;
      else if (sub < 75) line_left = $urandom_range(1, 8);
      else line_left = $urandom_range(COLS - 4, COLS + 8);
    end else begin
      line_left--;
      sub = $urandom_range(0, 99);
      if (sub < 8) begin
        w.code[6:0] = (sub < 4) ? CH_BS : CH_ULINE;
      end else if (sub < 11) begin
        w.code[6:0] = 7'($urandom_range(0, CH_PRINT_LO - 1));
        // push CR and BS over to codes that are ignored
        if (w.code[6:0] == CH_CR || w.code[6:0] == CH_BS) w.code[4] = 1'b1;
      end else begin
        w.code[6:0] = 7'($urandom_range(CH_PRINT_LO, 7'h7F));
      end
    end
  endtask

  task automatic send_word(input script_row_t w);
    int             gap;
    cursor_status_t st;
    gap = ((sent_count % 100) >= 70) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= w.op;
    in_char_code <= w.code;
    in_row_sel <= w.rs;
    in_col_sel <= w.cs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    display_step(w.op, w.code, w.rs, w.cs, st);
    status_due_q.push_back(w.fixed ? w.want : st);
    sent_count++;
  endtask

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // result side: random stalls, with a quiet stretch every 128 words
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ((status_count % 128) < 96 && $urandom_range(0, 99) < 30) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : status_check
    cursor_status_t want;
    if (rst_n && out_valid && out_ready) begin
      status_count <= status_count + 1;
      if (status_due_q.size() == 0) begin
        note_mismatch("result word with nothing pending", 0, 0);
      end else begin
        want = status_due_q.pop_front();
        if (out_cell_value !== want.value)
          note_mismatch("cell_value", out_cell_value, want.value);
        if (out_cur_row !== want.row)
          note_mismatch("cur_row", out_cur_row, want.row);
        if (out_cur_col !== want.col)
          note_mismatch("cur_col", out_cur_col, want.col);
        if (out_line_wrapped !== want.wrapped)
          note_mismatch("line_wrapped", out_line_wrapped, want.wrapped);
        if (out_consumed !== want.consumed)
          note_mismatch("consumed", out_consumed, want.consumed);
      end
    end
  end

  initial begin
    script_row_t w;
    clear_shadow();

    // fresh screen, store extremes and off-screen addresses
    script_add(OP_READ, 0, 0, 0, FIX, CELL_SPACE, 0, 0, 0, 0);
    script_add(OP_READ, 0, ROWS - 1, COLS - 1, FIX, CELL_SPACE, 0, 0, 0, 0);
    script_add(OP_READ, 0, 31, 63, FIX, 0, 0, 0, 0, 0);
    script_add(OP_POKE, 8'hFF, 0, 0, FIX, 0, 0, 0, 0, 1);
    script_add(OP_POKE, 8'h00, ROWS - 1, COLS - 1, FIX, 0, 0, 0, 0, 1);
    script_add(OP_POKE, 8'hAA, ROWS, 5, FIX, 0, 0, 0, 0, 0);
    script_add(OP_POKE, 8'h55, 3, COLS, FIX, 0, 0, 0, 0, 0);
    script_add(OP_READ, 0, 0, 0, FIX, 8'hFF, 0, 0, 0, 0);
    script_add(OP_READ, 0, ROWS - 1, COLS - 1, FIX, 8'h00, 0, 0, 0, 0);
    script_add(OP_READ, 0, 0, COLS, FIX, 0, 0, 0, 0, 0);
    // bell: a control code that is dropped
    script_add(OP_PUT, 8'h07, 0, 0, FIX, 0, 0, 0, 0, 0);
    // lowercase with bit 7 set, then DEL folding to underscore
    script_add(OP_PUT, 8'hE1, 0, 0, CALC, 0, 0, 0, 0, 0);
    script_add(OP_PUT, 8'h7F, 0, 0, CALC, 0, 0, 0, 0, 0);
    script_add(OP_PUT, {1'b0, CH_BS}, 0, 0, CALC, 0, 0, 0, 0, 0);
    script_add(OP_PUT, {1'b1, CH_ULINE}, 0, 0, CALC, 0, 0, 0, 0, 0);
    // backspace at the left margin
    script_add(OP_PUT, {1'b0, CH_BS}, 0, 0, FIX, 0, 0, 0, 0, 1);
    script_add(OP_PUT, {1'b1, CH_CR}, 0, 0, FIX, 0, 1, 0, 1, 1);
    script_add(OP_PUT, 8'hA0, 0, 0, CALC, 0, 0, 0, 0, 0);
    script_add(OP_READ, 0, 0, 1, CALC, 0, 0, 0, 0, 0);
    script_add(OP_FILL, 8'hFF, 31, 63, FIX, 0, 1, 1, 0, 1);
    script_add(OP_READ, 0, 5, 1, FIX, STRIPE_ODD, 1, 1, 0, 0);
    script_add(OP_READ, 0, 5, 0, FIX, STRIPE_EVEN, 1, 1, 0, 0);
    script_add(OP_SPARE_LO, 0, 0, 0, FIX, 0, 1, 1, 0, 0);
    script_add(OP_SPARE_HI, 8'hFF, 31, 63, FIX, 0, 1, 1, 0, 0);
    script_add(OP_CLEAR, 0, 0, 0, FIX, 0, 0, 0, 0, 1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_q[i]) send_word(script_q[i]);
    repeat (RAND_WORDS) begin
      next_random_word(w);
      send_word(w);
    end
    in_valid <= 1'b0;

    while (status_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/ttdg_pkg.sv
src/ttdg_ram.sv
src/ttdg_front.sv
src/ttdg_back.sv
src/teletype_text_display_grid.sv
src/ttdg_checker.sv
sim/tb_teletype_text_display_grid.sv
